// ===== src/tpa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared widths, register indexes, status codes and record types for the
// tachometer period averager.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int PERIOD_WIDTH = 16;
    localparam int AVG_SAMPLES  = 4;   // power of two, 2 to 16
    localparam int AVG_LOG2     = $clog2(AVG_SAMPLES);
    localparam int SUM_WIDTH    = PERIOD_WIDTH + AVG_LOG2;
    localparam int CORR_WIDTH   = 8;
    localparam int CFG_IDX_W    = 2;

    localparam logic [PERIOD_WIDTH-1:0] MAX_PERIOD_RST = PERIOD_WIDTH'(5000);
    localparam logic [PERIOD_WIDTH-1:0] MIN_PERIOD_RST = PERIOD_WIDTH'(100);
    localparam logic [CORR_WIDTH-1:0]   CORRECTION_RST = CORR_WIDTH'(6);

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION = 2'd2;

    typedef enum logic [1:0] {
        SPEED_NORMAL  = 2'd0,
        SPEED_MAXIMUM = 2'd1,
        SPEED_STOPPED = 2'd2
    } speed_t;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] max_period;
        logic [PERIOD_WIDTH-1:0] min_period;
        logic [CORR_WIDTH-1:0]   correction;
    } cfg_t;

    // Packed high-to-low as declared, which matches the output tdata layout.
    typedef struct packed {
        speed_t                  speed_status;
        logic [PERIOD_WIDTH-1:0] average_period;
        logic                    average_ready;
        logic [PERIOD_WIDTH-1:0] last_period;
        logic                    edge_seen;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int S_DATA_W = 8;

endpackage

// ===== src/tpa_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tpa_cfg_regs
// Configuration register file: maximum period, minimum period, correction.
// ----------------------------------------------------------------------------
module tpa_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output tpa_pkg::cfg_t                 cfg
);
    import tpa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_PERIOD: cfg_next.max_period = cfg_data[PERIOD_WIDTH-1:0];
                REG_MIN_PERIOD: cfg_next.min_period = cfg_data[PERIOD_WIDTH-1:0];
                REG_CORRECTION: cfg_next.correction = cfg_data[CORR_WIDTH-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_period <= MAX_PERIOD_RST;
            cfg_reg.min_period <= MIN_PERIOD_RST;
            cfg_reg.correction <= CORRECTION_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/tpa_datapath.sv =====
// ----------------------------------------------------------------------------
// tpa_datapath
// Edge detect, saturating tick counter, capture accumulator and mean with
// correction; updates its state when a sample advances.
// ----------------------------------------------------------------------------
module tpa_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             level,
    input  tpa_pkg::cfg_t    cfg,
    output tpa_pkg::result_t result
);
    import tpa_pkg::*;

    logic                    prev_reg,  prev_next;
    logic [PERIOD_WIDTH-1:0] tick_reg,  tick_next;
    logic [PERIOD_WIDTH-1:0] capt_reg,  capt_next;
    logic [SUM_WIDTH-1:0]    sum_reg,   sum_next;
    logic [AVG_LOG2-1:0]     ncap_reg,  ncap_next;
    logic [PERIOD_WIDTH-1:0] avg_reg,   avg_next;

    logic                    edge_det;
    logic                    fire;
    logic [PERIOD_WIDTH:0]   count_inc;
    logic [PERIOD_WIDTH-1:0] count;
    logic [SUM_WIDTH-1:0]    sum_inc;
    logic [PERIOD_WIDTH:0]   mean_wide;
    logic [PERIOD_WIDTH-1:0] mean;

    always_comb begin
        edge_det  = prev_reg & ~level;
        count_inc = {1'b0, tick_reg} + (PERIOD_WIDTH+1)'(1);
        count     = (count_inc > {1'b0, cfg.max_period}) ? cfg.max_period
                                                         : count_inc[PERIOD_WIDTH-1:0];
        sum_inc   = sum_reg + SUM_WIDTH'(count);
        fire      = (ncap_reg == AVG_LOG2'(AVG_SAMPLES - 1));
        mean_wide = {1'b0, sum_inc[SUM_WIDTH-1:AVG_LOG2]}
                  + (PERIOD_WIDTH+1)'(cfg.correction);
        mean      = mean_wide[PERIOD_WIDTH] ? {PERIOD_WIDTH{1'b1}}
                                            : mean_wide[PERIOD_WIDTH-1:0];

        prev_next = level;
        tick_next = tick_reg;
        capt_next = capt_reg;
        sum_next  = sum_reg;
        ncap_next = ncap_reg;
        avg_next  = avg_reg;

        if (edge_det) begin
            capt_next = count;
            tick_next = '0;
            if (fire) begin
                avg_next  = mean;
                sum_next  = '0;
                ncap_next = '0;
            end else begin
                sum_next  = sum_inc;
                ncap_next = ncap_reg + AVG_LOG2'(1);
            end
        end else begin
            tick_next = count;
            if (count >= cfg.max_period) begin
                avg_next  = cfg.max_period;
                sum_next  = '0;
                ncap_next = '0;
            end
        end

        result.edge_seen      = edge_det;
        result.last_period    = capt_next;
        result.average_ready  = edge_det & fire;
        result.average_period = avg_next;
        if (avg_next <= cfg.min_period) begin
            result.speed_status = SPEED_MAXIMUM;
        end else if (avg_next >= cfg.max_period) begin
            result.speed_status = SPEED_STOPPED;
        end else begin
            result.speed_status = SPEED_NORMAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= 1'b1;
            tick_reg <= '0;
            capt_reg <= '0;
            sum_reg  <= '0;
            ncap_reg <= '0;
            avg_reg  <= '0;
        end else if (advance) begin
            prev_reg <= prev_next;
            tick_reg <= tick_next;
            capt_reg <= capt_next;
            sum_reg  <= sum_next;
            ncap_reg <= ncap_next;
            avg_reg  <= avg_next;
        end
    end

endmodule

// ===== src/tachometer_period_averager_unit.sv =====
// ----------------------------------------------------------------------------
// tachometer_period_averager_unit
// Measures sensor periods from per-tick samples and reports a four-capture
// mean with correction and a speed status, one result per tick.
//
//   Channel | Ports                        | Carries
//   --------+------------------------------+-------------------------------
//   input   | s_tvalid s_tready s_tdata    | one tick sample
//   result  | m_tvalid m_tready m_tdata    | one result per tick
//   config  | cfg_valid cfg_ready cfg_*    | register index and write data
//
// One tick per cycle while the result side is not stalled; a request passes
// the input register and then the output register from accept to result.
// Reset (aresetn low, synchronous) empties both registers and restores the
// register defaults. A stalled result holds in the output register while the
// input register still takes the next request; input stalls only when both
// are full.
// ----------------------------------------------------------------------------
module tachometer_period_averager_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tpa_pkg::S_DATA_W-1:0]  s_tdata,   // [0] sensor_level
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] edge_seen, [16:1] last_period, [17] average_ready,
    // [33:18] average_period, [35:34] speed_status
    output logic [tpa_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import tpa_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t res_reg;
    logic    in_valid_reg;
    logic    level_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(res_reg);

    tpa_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpa_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .level   (level_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            level_reg <= s_tdata[0];
        end
        if (advance) begin
            res_reg <= result;
        end
    end

endmodule

// ===== src/tpa_checker.sv =====
// ----------------------------------------------------------------------------
// tpa_checker
// Port-level checks for the tachometer period averager, bound to the top.
// ----------------------------------------------------------------------------
module tpa_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [tpa_pkg::M_DATA_W-1:0] m_tdata
);
    import tpa_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A new mean only comes with a falling edge.
    a_ready_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17] |-> m_tdata[0])
        else $error("average_ready without edge_seen");

    // Drop nothing out of reset: empty output, input open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not empty after reset");

    // Advance the input while the output is free.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind tachometer_period_averager_unit tpa_checker u_tpa_checker (.*);

// ===== test/tb_tachometer_period_averager_unit.sv =====
// ----------------------------------------------------------------------------
// tb_tachometer_period_averager_unit
// Drives sensor tick samples into the period averager and checks every
// per-tick report against a local tachometer model: edge capture, counter
// saturation, four-capture mean with correction, and speed status. Runs
// directed cases and random pulse trains under several sender and receiver
// idling mixes and register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tachometer_period_averager_unit;

    import tpa_pkg::*;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RANDOM_TICKS   = 150;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]           cfg_data  = '0;

    tachometer_period_averager_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // tachometer model state and registers
    logic [PERIOD_WIDTH-1:0] max_p       = MAX_PERIOD_RST;
    logic [PERIOD_WIDTH-1:0] min_p       = MIN_PERIOD_RST;
    logic [CORR_WIDTH-1:0]   corr        = CORRECTION_RST;
    logic                    prev_level  = 1'b1;
    logic [PERIOD_WIDTH-1:0] ticks       = '0;
    logic [PERIOD_WIDTH-1:0] captured    = '0;
    int unsigned             period_acc  = 0;
    int unsigned             captures    = 0;
    logic [PERIOD_WIDTH-1:0] averaged    = '0;

    logic    sensor_samples[$];
    result_t tick_reports[$];
    int      samples_queued = 0;
    int      bad_reports    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      holdoff_left   = 0;
    logic    holdoff_start  = 1'b0;
    int      cycle_count    = 0;
    result_t seen_report;
    result_t due_report;

    function automatic result_t tachometer_tick(logic level);
        logic [PERIOD_WIDTH:0] count;
        logic                  fell;
        int unsigned           mean;
        result_t               r;
        fell  = prev_level && !level;
        prev_level = level;
        count = {1'b0, ticks} + 1'b1;
        if (count > {1'b0, {PERIOD_WIDTH{1'b1}}}) count = {1'b0, {PERIOD_WIDTH{1'b1}}};
        if (count > {1'b0, max_p}) count = {1'b0, max_p};
        r.average_ready = 1'b0;
        if (fell) begin
            captured   = count[PERIOD_WIDTH-1:0];
            ticks      = '0;
            period_acc = period_acc + count;
            captures   = captures + 1;
            if (captures >= AVG_SAMPLES) begin
                mean = period_acc / AVG_SAMPLES + corr;
                if (mean > 32'hFFFF) mean = 32'hFFFF;
                averaged        = mean[PERIOD_WIDTH-1:0];
                period_acc      = 0;
                captures        = 0;
                r.average_ready = 1'b1;
            end
        end else begin
            ticks = count[PERIOD_WIDTH-1:0];
            if (count >= {1'b0, max_p}) begin
                averaged   = max_p;
                period_acc = 0;
                captures   = 0;
            end
        end
        if (averaged <= min_p) begin
            r.speed_status = SPEED_MAXIMUM;
        end else if (averaged >= max_p) begin
            r.speed_status = SPEED_STOPPED;
        end else begin
            r.speed_status = SPEED_NORMAL;
        end
        r.edge_seen      = fell;
        r.last_period    = captured;
        r.average_period = averaged;
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            REG_MAX_PERIOD: max_p = data[PERIOD_WIDTH-1:0];
            REG_MIN_PERIOD: min_p = data[PERIOD_WIDTH-1:0];
            REG_CORRECTION: corr  = data[CORR_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    function automatic void push_sample(logic level);
        sensor_samples.push_back(level);
        samples_queued++;
    endfunction

    function automatic void push_bits(logic [31:0] bits, int n);
        for (int i = 0; i < n; i++) push_sample(bits[i]);
    endfunction

    // low stretch, high stretch, then the falling edge: p ticks after the last edge
    function automatic void push_period(int p);
        int lows;
        lows = $urandom_range(0, p - 2);
        for (int i = 0; i < lows; i++) push_sample(1'b0);
        for (int i = 0; i < p - 1 - lows; i++) push_sample(1'b1);
        push_sample(1'b0);
    endfunction

    // hold valid high; the caller drops it after the last write of a group
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, data);
    endtask

    task automatic drain();
        while (sensor_samples.size() != 0 || tick_reports.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    task automatic run_random(int send_pct, int recv_pct, bit hold, int n);
        logic [PERIOD_WIDTH-1:0] mx;
        logic [PERIOD_WIDTH-1:0] mn;
        logic [CORR_WIDTH-1:0]   cr;
        int                      start;
        mx = PERIOD_WIDTH'($urandom_range(6, 40));
        mn = PERIOD_WIDTH'($urandom_range(0, mx));
        cr = ($urandom_range(0, 3) == 0) ? CORR_WIDTH'($urandom_range(0, 255))
                                         : CORR_WIDTH'($urandom_range(0, 8));
        write_reg(REG_MAX_PERIOD, {16'($urandom()), mx});
        write_reg(REG_MIN_PERIOD, {16'($urandom()), mn});
        write_reg(REG_CORRECTION, {24'($urandom()), cr});
        cfg_valid <= 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold) holdoff_start <= 1'b1;
        start = samples_queued;
        while (samples_queued - start < n) begin
            if ($urandom_range(0, 99) < 80) begin
                push_period($urandom_range(2, mx + 3));
            end else begin
                push_bits($urandom(), $urandom_range(1, 6));
            end
        end
        @(posedge aclk);
        holdoff_start <= 1'b0;
        drain();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tick_reports.push_back(tachometer_tick(s_tdata[0]));
                void'(sensor_samples.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (sensor_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'(sensor_samples[0]);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (holdoff_start) begin
            holdoff_left <= HOLDOFF_CYCLES;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_report = result_t'(m_tdata[RESULT_W-1:0]);
                if (tick_reports.size() == 0) begin
                    if (bad_reports < 10)
                        $display("unexpected report: %p", seen_report);
                    bad_reports++;
                end else begin
                    due_report = tick_reports.pop_front();
                    if (seen_report.edge_seen != due_report.edge_seen
                            || seen_report.last_period != due_report.last_period
                            || seen_report.average_ready != due_report.average_ready
                            || seen_report.average_period != due_report.average_period
                            || seen_report.speed_status != due_report.speed_status) begin
                        if (bad_reports < 10)
                            $display("report mismatch: expected %p, actual %p",
                                     due_report, seen_report);
                        bad_reports++;
                    end
                end
            end
            m_tready <= holdoff_left == 0 && !holdoff_start
                        && $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_tachometer_period_averager_unit failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: first low sample is an edge, reset status is max speed
        push_bits(32'b10110, 5);
        drain();

        // zero max period, ignored index, masked data
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_MAX_PERIOD, 32'hFFFF_0000);
        write_reg(REG_MIN_PERIOD, 32'h0000_FFFF);
        cfg_valid <= 1'b0;
        push_bits(32'b01001, 5);
        drain();

        // shortest periods to max speed, then counter saturation
        write_reg(REG_MAX_PERIOD, 32'h1234_000A);
        write_reg(REG_MIN_PERIOD, 32'h0000_0003);
        write_reg(REG_CORRECTION, 32'hFFFF_FF00);
        cfg_valid <= 1'b0;
        for (int i = 0; i < AVG_SAMPLES; i++) push_period(2);
        push_bits(32'hFFF, 12);
        drain();

        // saturate while low to clear the partial sum
        write_reg(REG_MAX_PERIOD, 32'h0000_0004);
        write_reg(REG_CORRECTION, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        push_bits(32'b01, 8);
        drain();

        run_random(0, 0, 1'b1, RANDOM_TICKS);
        run_random(87, 0, 1'b0, RANDOM_TICKS);
        run_random(0, 87, 1'b0, RANDOM_TICKS);
        run_random(16, 16, 1'b0, RANDOM_TICKS);

        repeat (10) @(posedge aclk);
        if (bad_reports == 0 && tick_reports.size() == 0) begin
            $display("tb_tachometer_period_averager_unit passed");
        end else begin
            $display("tb_tachometer_period_averager_unit failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tpa_pkg.sv
src/tpa_cfg_regs.sv
src/tpa_datapath.sv
src/tachometer_period_averager_unit.sv
src/tpa_checker.sv
test/tb_tachometer_period_averager_unit.sv
